>>> hdl/tte_pkg.sv
`timescale 1ns / 1ps

package tte_pkg;

    // Ring of held taps
    localparam int TAP_WINDOW = 4;
    localparam int SLOT_W     = $clog2(TAP_WINDOW);
    localparam int COUNT_W    = $clog2(TAP_WINDOW + 1);

    // Payload widths
    localparam int TAP_TIME_W = 64;
    localparam int TEMPO_W    = 17;
    localparam int GAP_W      = 32;
    localparam int BPM_W      = 9;
    localparam int FRAC_W     = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = GAP_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BPM   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BPM   = 2'd2;

    localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 32'd2000000;
    localparam logic [BPM_W-1:0] MIN_BPM_RESET   = 9'd20;
    localparam logic [BPM_W-1:0] MAX_BPM_RESET   = 9'd300;

    // 60e6 us per minute times 256 for the Q9.8 result
    localparam longint unsigned TEMPO_SCALE_VAL = 64'd15360000000;
    localparam int DIV_W   = $clog2(TEMPO_SCALE_VAL * (TAP_WINDOW - 1) + 1);
    localparam int STEP_W  = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] TEMPO_SCALE = DIV_W'(TEMPO_SCALE_VAL);

    // Slot that lies back entries before from, modulo the ring size
    function automatic logic [SLOT_W-1:0] slot_back(
        input logic [SLOT_W-1:0]  from,
        input logic [COUNT_W-1:0] back
    );
        logic [COUNT_W+SLOT_W:0] sum;
        sum = (COUNT_W+SLOT_W+1)'(from) + (COUNT_W+SLOT_W+1)'(TAP_WINDOW)
            - (COUNT_W+SLOT_W+1)'(back);
        if (sum >= (COUNT_W+SLOT_W+1)'(TAP_WINDOW))
        begin
            sum = sum - (COUNT_W+SLOT_W+1)'(TAP_WINDOW);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

>>> hdl/tte_tap_if.sv
`timescale 1ns / 1ps

interface tte_tap_if import tte_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TAP_TIME_W-1:0] tap_time_us;

    modport source (output valid, output tap_time_us, input ready);
    modport sink   (input valid, input tap_time_us, output ready);
endinterface

>>> hdl/tte_tempo_if.sv
`timescale 1ns / 1ps

interface tte_tempo_if import tte_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TEMPO_W-1:0] tempo_q8;
    logic               tempo_valid;

    modport source (output valid, output tempo_q8, output tempo_valid, input ready);
    modport sink   (input valid, input tempo_q8, input tempo_valid, output ready);
endinterface

>>> hdl/tte_ram.sv
`timescale 1ns / 1ps

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tap_tempo_estimator_unit.sv
`timescale 1ns / 1ps
// Sequence: a tap with two or more held taps and a nonzero span goes through the check,
//   fetch, divide and finish states, the divide running over all DIV_W bits of the 36-bit dividend.
//   Other taps (history too short or zero span) go from fetch straight to finish.
// Flow: no new tap is taken until finish has put the last word into the output register;
//   the bit-serial restoring divider works one quotient bit per cycle.
// Reset (rst_n low, async): history empty, registers back to 2000000 us / 20 / 300 BPM.

module tap_tempo_estimator_unit import tte_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    tte_tap_if.sink                  tap,
    tte_tempo_if.source              tempo,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [GAP_W-1:0] gap_reg;
    logic [BPM_W-1:0] min_reg;
    logic [BPM_W-1:0] max_reg;

    // Tap history control; the tap times themselves live in the ring RAM
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [COUNT_W-1:0]    held_reg, held_next;
    logic [TAP_TIME_W-1:0] last_reg, last_next;
    logic [TAP_TIME_W-1:0] now_reg, now_next;

    // Divider datapath
    logic [TAP_TIME_W-1:0] span_reg, span_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  zero_reg, zero_next;

    // Output word register
    logic               out_valid_reg, out_valid_next;
    logic [TEMPO_W-1:0] out_q8_reg, out_q8_next;
    logic               out_tv_reg, out_tv_next;

    // RAM port signals
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [TAP_TIME_W-1:0] ram_rdata;

    // Gap check
    logic [TAP_TIME_W-1:0] gap_diff;
    logic                  restart;
    logic [SLOT_W-1:0]     base_slot;
    logic [COUNT_W-1:0]    base_held;

    // Span subtract, division-step subtract/compare, and clamp
    logic [TAP_TIME_W-1:0] fetch_span;
    logic [COUNT_W-1:0]    held_m1;
    logic [DIV_W:0]        trial;
    logic [TAP_TIME_W-1:0] trial_ext;
    logic [TAP_TIME_W-1:0] trial_diff;
    logic                  trial_ge;
    logic [DIV_W-1:0]      lo_bound;
    logic [DIV_W-1:0]      hi_bound;
    logic [DIV_W-1:0]      clamp_lo;
    logic [DIV_W-1:0]      clamp_hi;

    logic tap_fire;
    logic out_fire;

    assign tap_fire = tap.valid && tap.ready;
    assign out_fire = tempo.valid && tempo.ready;

    assign tap.ready         = (state_reg == ST_IDLE);
    assign tempo.valid       = out_valid_reg;
    assign tempo.tempo_q8    = out_q8_reg;
    assign tempo.tempo_valid = out_tv_reg;

    // Ring of the last TAP_WINDOW taps: written with the new tap, read at the oldest
    tte_ram #(
        .WIDTH (TAP_TIME_W),
        .DEPTH (TAP_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_LIMIT_RESET;
            min_reg <= MIN_BPM_RESET;
            max_reg <= MAX_BPM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_LIMIT: gap_reg <= cfg_data[GAP_W-1:0];
                CFG_MIN_BPM:   min_reg <= cfg_data[BPM_W-1:0];
                CFG_MAX_BPM:   max_reg <= cfg_data[BPM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Restart the history when the gap since the newest held tap is too long
    assign gap_diff  = now_reg - last_reg;
    assign restart   = (held_reg != '0) && (gap_diff > TAP_TIME_W'(gap_reg));
    assign base_slot = restart ? '0 : slot_reg;
    assign base_held = restart ? '0 : held_reg;

    // Span from the oldest held tap (RAM data) to the newest (this tap)
    assign fetch_span = now_reg - ram_rdata;
    assign held_m1    = held_reg - COUNT_W'(1);

    // One restoring division step: shift in the next dividend bit, compare, subtract
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ext  = TAP_TIME_W'(trial);
    assign trial_diff = trial_ext - span_reg;
    assign trial_ge   = (trial_ext >= span_reg);

    // Lower clamp first, then upper, so an inverted range lands on the maximum
    assign lo_bound = DIV_W'({min_reg, {FRAC_W{1'b0}}});
    assign hi_bound = DIV_W'({max_reg, {FRAC_W{1'b0}}});
    assign clamp_lo = (quo_reg < lo_bound) ? lo_bound : quo_reg;
    assign clamp_hi = (clamp_lo > hi_bound) ? hi_bound : clamp_lo;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        last_next      = last_reg;
        now_next       = now_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_q8_next    = out_q8_reg;
        out_tv_next    = out_tv_reg;
        ram_we         = 1'b0;
        ram_waddr      = base_slot;
        ram_raddr      = '0;

        // Release the output word once taken
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tap_fire)
                begin
                    now_next   = tap.tap_time_us;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Store the tap, advance the slot, bump the saturating count,
                // and address the oldest held tap for the next cycle
                ram_we    = 1'b1;
                slot_next = (base_slot == SLOT_W'(TAP_WINDOW - 1))
                          ? '0 : base_slot + SLOT_W'(1);
                held_next = (base_held < COUNT_W'(TAP_WINDOW))
                          ? base_held + COUNT_W'(1) : base_held;
                ram_raddr = slot_back(slot_next, held_next);
                last_next = now_reg;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                span_next = fetch_span;
                rem_next  = '0;
                quo_next  = DIV_W'(TEMPO_SCALE * DIV_W'(held_m1));
                step_next = '0;
                if ((held_reg < COUNT_W'(2)) || (fetch_span == '0))
                begin
                    zero_next  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_next  = {quo_reg[DIV_W-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || tempo.ready)
                begin
                    out_valid_next = 1'b1;
                    out_q8_next    = zero_reg ? '0 : clamp_hi[TEMPO_W-1:0];
                    out_tv_next    = !zero_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            held_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        now_reg    <= now_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        zero_reg   <= zero_next;
        out_q8_reg <= out_q8_next;
        out_tv_reg <= out_tv_next;
    end

    // The held count never passes the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= COUNT_W'(TAP_WINDOW))
        else $error("held tap count exceeds ring size");

    // A word that carries no tempo carries a zero tempo
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_tv_reg) |-> (out_q8_reg == '0))
        else $error("invalid tempo word with nonzero tempo");

    // The unit is busy in the cycle after it takes a tap
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_fire |=> !tap.ready)
        else $error("tap taken while previous tap in progress");

    // A division never runs past its last quotient bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (step_reg < STEP_W'(DIV_W)))
        else $error("divider step count overran");

endmodule
